// ===== rtl/bpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TICK_COUNT_WIDTH = 32;
    localparam int CFG_WIDTH        = 32;
    localparam int CMP_WIDTH        = (TICK_COUNT_WIDTH > CFG_WIDTH) ?
                                      TICK_COUNT_WIDTH : CFG_WIDTH;
    localparam int CFG_INDEX_WIDTH  = 2;

    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = {TICK_COUNT_WIDTH{1'b1}};

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(50000);
    localparam logic [CFG_WIDTH-1:0] SHORT_RESET    = CFG_WIDTH'(1000000);
    localparam logic [CFG_WIDTH-1:0] LONG_RESET     = CFG_WIDTH'(2000000);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_SHORT    = 2'd1,
        REG_LONG     = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_PRESSED  = 2'd2,
        MODE_HOLD     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_LONG  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] short_press_ticks;
        logic [CFG_WIDTH-1:0] long_press_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/button_press_classifier_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier_core
// Debounced push-button classifier: one sample word in, one press kind out.
// ----------------------------------------------------------------------------
// Slave stream: one word per sample tick, s_tdata[0] is the pin level.
// Master stream: one word per sample, m_tdata[1:0] is the press kind
// (none, short or long, reported on release of a confirmed press).
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 debounce, 1 short, 2 long threshold in ticks. cfg_ready is always
// high; write only while no word is in flight.
// Flow: a word taken into the input register is classified and registered
// into the result register once the output stage can advance, and m_tvalid
// then rises. Throughput is one word per cycle while the receiver accepts,
// set by the single mode and counter update between the input and
// result registers.
// A stalled receiver holds m_tdata; the input register still takes one
// further word, and s_tready drops only when both stages are full.
// Reset clears both stages, mode to idle, the counter to zero and the
// thresholds to their defaults.
// ----------------------------------------------------------------------------
module button_press_classifier_core
    import bpc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [0] button_level, [7:1] zero
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // [1:0] press_kind, [7:2] zero
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

    cfg_t  cfg;
    kind_t kind;
    logic  in_valid_reg;
    logic  level_reg;
    logic  out_valid_reg;
    kind_t kind_reg;
    logic  advance;
    logic  step;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .level (level_reg),
        .cfg   (cfg),
        .kind  (kind)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, kind_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            level_reg <= s_tdata[0];
        if (step)
            kind_reg <= kind;
    end

endmodule
`default_nettype wire

// ===== rtl/bpc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_RESET;
            cfg_reg.short_press_ticks <= SHORT_RESET;
            cfg_reg.long_press_ticks  <= LONG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks    <= cfg_data;
                REG_SHORT:    cfg_reg.short_press_ticks <= cfg_data;
                REG_LONG:     cfg_reg.long_press_ticks  <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bpc_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_fsm
// Mode register and saturating tick counter; classifies one tick per step.
// ----------------------------------------------------------------------------
module bpc_fsm
    import bpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic level,
    input  wire cfg_t cfg,
    output kind_t     kind
);

    mode_t                       mode_reg;
    mode_t                       mode_next;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_reg;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_next;
    logic [TICK_COUNT_WIDTH-1:0] e_sat;
    logic [CMP_WIDTH-1:0]        e_ext;
    logic                        over_debounce;
    logic                        at_long;
    logic                        at_short;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_comb
    begin
        e_sat         = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        e_ext         = CMP_WIDTH'(e_sat);
        over_debounce = e_ext >  CMP_WIDTH'(cfg.debounce_ticks);
        at_long       = e_ext >= CMP_WIDTH'(cfg.long_press_ticks);
        at_short      = e_ext >= CMP_WIDTH'(cfg.short_press_ticks);
        mode_next     = mode_reg;
        elapsed_next  = e_sat;
        kind          = KIND_NONE;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (level)
                begin
                    mode_next    = MODE_DEBOUNCE;
                    elapsed_next = '0;
                end
            end
            MODE_DEBOUNCE:
            begin
                if (over_debounce)
                begin
                    if (level)
                    begin
                        mode_next    = MODE_PRESSED;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_PRESSED:
            begin
                if (!level)
                begin
                    mode_next = MODE_IDLE;
                    if (at_long)
                        kind = KIND_LONG;
                    else if (at_short)
                        kind = KIND_SHORT;
                end
                else if (at_long)
                begin
                    mode_next = MODE_HOLD;
                end
            end
            default:
            begin
                if (!level)
                begin
                    mode_next = MODE_IDLE;
                    kind      = KIND_LONG;
                end
            end
        endcase
    end

    // report only on release of a confirmed press
    a_kind_from_press: assert property (@(posedge clk) disable iff (!rst_n)
        (step && kind != KIND_NONE) |->
        ((mode_reg == MODE_PRESSED || mode_reg == MODE_HOLD) && !level))
        else $error("press reported outside a confirmed press");

    a_hold_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HOLD) |=> (mode_reg == MODE_HOLD || mode_reg == MODE_IDLE))
        else $error("hold left to a mode other than idle");

    a_state_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(mode_reg) && $stable(elapsed_reg)))
        else $error("state moved without a word");

    a_press_from_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_IDLE) |=> (mode_reg != MODE_PRESSED))
        else $error("press confirmed without debounce");

endmodule
`default_nettype wire
